// ===== rtl/falts_pkg.sv =====
package falts_pkg;

    // Fixed field widths
    localparam int ADDR_W      = 32;
    localparam int STAMP_W     = 32;
    localparam int COUNT_W     = 32;
    localparam int LINE_USED_W = 4;
    localparam int EV_TAG_W    = 26;

    // Default geometry
    localparam int LINES_DEF       = 16;
    localparam int OFFSET_BITS_DEF = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // Scan result flags
    typedef struct packed {
        logic hit;    // tag matched a valid line
        logic found;  // at least one valid line seen, oldest is held
    } t_scan_stat;

endpackage

// ===== rtl/fully_associative_lru_tag_store_core.sv =====
// Fully associative tag store with true LRU replacement. Each input word is a
// byte address; the low OFFSET_BITS bits are dropped to form the tag, which is
// looked up across LINES lines. A hit restamps the line with the current access
// number; a miss fills the lowest free line, or once all lines are in use,
// replaces the line with the oldest stamp (lowest index on ties) and reports
// its tag as evicted. Each input word gives one result word with the hit flag,
// the line used, eviction info and saturating hit/access counts. Lines fill in
// index order and never empty, so a fill count stands in for valid bits and no
// clearing pass is needed after reset. A word is handled in steps, in order:
// it is accepted, each filled line is read in turn through the shared
// tag/stamp read address and compared, the read register is drained, and
// the result is written back. The input is not ready while a word is being
// worked on; a finished result sits in the output register, and write-back
// of the next word waits only if that result has not yet been taken.
module fully_associative_lru_tag_store_core
    import falts_pkg::*;
#(
    parameter int LINES       = LINES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [ADDR_W-1:0]      i_address,
    // output channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_hit,
    output logic [LINE_USED_W-1:0] o_line_used,
    output logic                   o_evicted_valid,
    output logic [EV_TAG_W-1:0]    o_evicted_tag,
    output logic [COUNT_W-1:0]     o_hits_so_far,
    output logic [COUNT_W-1:0]     o_accesses_so_far
);

    localparam int TAG_W = ADDR_W - OFFSET_BITS;
    localparam int IDX_W = $clog2(LINES);
    localparam int CNT_W = $clog2(LINES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LINES);

    t_state r_state;
    t_state n_state;

    // current word
    logic [TAG_W-1:0]   r_tag;
    // lines in use: line i is valid when i < r_fill
    logic [CNT_W-1:0]   r_fill;
    logic [COUNT_W-1:0] r_hits;
    logic [COUNT_W-1:0] r_accs;

    // scan pointers
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;

    // output register
    logic                   r_out_valid;
    logic                   r_hit_o;
    logic [LINE_USED_W-1:0] r_line_used;
    logic                   r_ev_valid;
    logic [EV_TAG_W-1:0]    r_ev_tag;
    logic [COUNT_W-1:0]     r_hits_o;
    logic [COUNT_W-1:0]     r_accs_o;

    // control from the sequencer
    logic in_ready;
    logic rd_en;
    logic scan_clr;
    logic upd_fire;
    logic out_free;
    logic scan_done;

    // memory and scan signals
    logic [TAG_W-1:0]   rd_tag;
    logic [STAMP_W-1:0] rd_stamp;
    t_scan_stat         scan_stat;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   min_idx;
    logic [TAG_W-1:0]   min_tag;

    // write-back values
    logic                   full;
    logic                   ev_valid;
    logic [IDX_W-1:0]       used_idx;
    logic [IDX_W+LINE_USED_W-1:0] used_ext;
    logic [TAG_W+EV_TAG_W-1:0]    ev_tag_ext;
    logic [COUNT_W-1:0]     hits_inc;
    logic [COUNT_W-1:0]     accs_inc;

    assign out_free  = !r_out_valid || i_out_ready;
    // last compare lands on the same edge that leaves the scan
    assign scan_done = !(r_rd_idx < r_fill);

    // ---- sequencer: next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        scan_clr = 1'b0;
        upd_fire = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                scan_clr = 1'b1;
            end
            ST_SCAN: begin
                rd_en = (r_rd_idx < r_fill);
            end
            ST_UPDATE: begin
                upd_fire = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- scan pointers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_rd_idx <= '0;
        end else if (rd_en) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end
        if (rd_en) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (in_ready && i_in_valid) begin
            r_tag <= i_address[ADDR_W-1:OFFSET_BITS];
        end
    end

    // ---- tag and stamp stores, one shared read address ----
    falts_mem #(
        .WIDTH (TAG_W),
        .DEPTH (LINES)
    ) u_tag_mem (
        .i_clk   (i_clk),
        .i_we    (upd_fire && !scan_stat.hit),
        .i_waddr (used_idx),
        .i_wdata (r_tag),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_tag)
    );

    falts_mem #(
        .WIDTH (STAMP_W),
        .DEPTH (LINES)
    ) u_stamp_mem (
        .i_clk   (i_clk),
        .i_we    (upd_fire),
        .i_waddr (used_idx),
        .i_wdata (r_accs),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_stamp)
    );

    // ---- match / oldest-line tracker ----
    falts_scan #(
        .LINES (LINES),
        .TAG_W (TAG_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (scan_clr),
        .i_cmp_vld    (r_cmp_vld),
        .i_cmp_idx    (r_cmp_idx),
        .i_key_tag    (r_tag),
        .i_line_tag   (rd_tag),
        .i_line_stamp (rd_stamp),
        .o_stat       (scan_stat),
        .o_hit_idx    (hit_idx),
        .o_min_idx    (min_idx),
        .o_min_tag    (min_tag)
    );

    // ---- write-back ----
    assign full     = (r_fill == FULL_CNT);
    assign ev_valid = !scan_stat.hit && full && scan_stat.found;

    always_comb begin
        if (scan_stat.hit) begin
            used_idx = hit_idx;
        end else if (full) begin
            used_idx = min_idx;
        end else begin
            used_idx = r_fill[IDX_W-1:0];
        end
    end

    assign used_ext   = {{LINE_USED_W{1'b0}}, used_idx};
    assign ev_tag_ext = {{EV_TAG_W{1'b0}}, min_tag};
    assign hits_inc   = (r_hits == '1) ? r_hits : r_hits + COUNT_W'(1);
    assign accs_inc   = (r_accs == '1) ? r_accs : r_accs + COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_hits      <= '0;
            r_accs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_fire) begin
                r_accs <= accs_inc;
                if (scan_stat.hit) begin
                    r_hits <= hits_inc;
                end else if (!full) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (upd_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_hit_o     <= scan_stat.hit;
            r_line_used <= used_ext[LINE_USED_W-1:0];
            r_ev_valid  <= ev_valid;
            r_ev_tag    <= ev_valid ? ev_tag_ext[EV_TAG_W-1:0] : '0;
            r_hits_o    <= scan_stat.hit ? hits_inc : r_hits;
            r_accs_o    <= accs_inc;
        end
    end

    assign o_in_ready        = in_ready;
    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_hit_o;
    assign o_line_used       = r_line_used;
    assign o_evicted_valid   = r_ev_valid;
    assign o_evicted_tag     = r_ev_tag;
    assign o_hits_so_far     = r_hits_o;
    assign o_accesses_so_far = r_accs_o;

endmodule

// ===== rtl/falts_mem.sv =====
module falts_mem #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/falts_scan.sv =====
module falts_scan
    import falts_pkg::*;
#(
    parameter int LINES = LINES_DEF,
    parameter int TAG_W = ADDR_W - OFFSET_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_cmp_vld,
    input  logic [$clog2(LINES)-1:0] i_cmp_idx,
    input  logic [TAG_W-1:0]         i_key_tag,
    input  logic [TAG_W-1:0]         i_line_tag,
    input  logic [STAMP_W-1:0]       i_line_stamp,
    output t_scan_stat               o_stat,
    output logic [$clog2(LINES)-1:0] o_hit_idx,
    output logic [$clog2(LINES)-1:0] o_min_idx,
    output logic [TAG_W-1:0]         o_min_tag
);

    localparam int IDX_W = $clog2(LINES);

    logic               r_hit;
    logic               r_min_vld;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [IDX_W-1:0]   r_min_idx;
    logic [STAMP_W-1:0] r_min_stamp;
    logic [TAG_W-1:0]   r_min_tag;

    logic match;
    logic older;

    // One tag compare and one stamp compare per cycle, one line at a time
    assign match = (i_line_tag == i_key_tag);
    assign older = !r_min_vld || (i_line_stamp < r_min_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hit     <= 1'b0;
            r_min_vld <= 1'b0;
        end else if (i_cmp_vld) begin
            if (!r_hit && match) begin
                r_hit <= 1'b1;
            end
            if (older) begin
                r_min_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp_vld) begin
            if (!r_hit && match) begin
                r_hit_idx <= i_cmp_idx;
            end
            // strict less-than keeps the lowest index on ties
            if (older) begin
                r_min_idx   <= i_cmp_idx;
                r_min_stamp <= i_line_stamp;
                r_min_tag   <= i_line_tag;
            end
        end
    end

    assign o_stat.hit   = r_hit;
    assign o_stat.found = r_min_vld;
    assign o_hit_idx    = r_hit_idx;
    assign o_min_idx    = r_min_idx;
    assign o_min_tag    = r_min_tag;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for the fully associative LRU tag store.
// A mirror of the tag store (tags, valid bits, age stamps, hit and access
// counts) is kept here and updated as each address word is accepted, so the
// expected result for every word is known before the block produces it.
// Results are checked in order against the queue of pending lookups.
module testbench
    import falts_pkg::*;
();

    localparam int TAG_W      = ADDR_W - OFFSET_BITS_DEF;
    localparam int WDOG_LIMIT = 2000;   // idle cycles before giving up
    localparam int HOLD_LONG  = 300;    // long receiver hold-off, in cycles
    localparam int SETTLE     = 25;     // longer than the worst word time

    // One result word as the block should report it
    typedef struct {
        logic                   hit;
        logic [LINE_USED_W-1:0] line;
        logic                   ev_valid;
        logic [EV_TAG_W-1:0]    ev_tag;
        logic [COUNT_W-1:0]     hits;
        logic [COUNT_W-1:0]     accesses;
    } t_lookup;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // Input channel
    logic              addr_valid = 1'b0;
    logic [ADDR_W-1:0] addr_word  = '0;
    logic              addr_ready;

    // Output channel
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic                   res_hit;
    logic [LINE_USED_W-1:0] res_line;
    logic                   res_ev_valid;
    logic [EV_TAG_W-1:0]    res_ev_tag;
    logic [COUNT_W-1:0]     res_hits;
    logic [COUNT_W-1:0]     res_accesses;

    // Mirror of the tag store
    logic [TAG_W-1:0]   mirror_tag   [LINES_DEF];
    logic               mirror_valid [LINES_DEF];
    logic [STAMP_W-1:0] mirror_stamp [LINES_DEF];
    logic [COUNT_W-1:0] mirror_hits;
    logic [COUNT_W-1:0] mirror_accesses;

    t_lookup pending_lookups[$];

    // Pacing knobs: idle and stall chances in percent, hold-off length in cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request   = 0;   // set by a test, picked up by the receiver
    int unsigned hold_left      = 0;

    // Working set for random traffic
    logic [TAG_W-1:0] tag_pool[32];
    int unsigned      pool_size = 20;

    int unsigned errors       = 0;
    int unsigned words_sent   = 0;
    int unsigned hits_seen    = 0;
    int unsigned evicts_seen  = 0;
    int unsigned idle_cycles  = 0;

    fully_associative_lru_tag_store_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (addr_valid),
        .o_in_ready        (addr_ready),
        .i_address         (addr_word),
        .o_out_valid       (res_valid),
        .i_out_ready       (res_ready),
        .o_hit             (res_hit),
        .o_line_used       (res_line),
        .o_evicted_valid   (res_ev_valid),
        .o_evicted_tag     (res_ev_tag),
        .o_hits_so_far     (res_hits),
        .o_accesses_so_far (res_accesses)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic logic [COUNT_W-1:0] sat_incr(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + COUNT_W'(1);
    endfunction

    function automatic void clear_mirror();
        for (int i = 0; i < LINES_DEF; i++) begin
            mirror_tag[i]   = '0;
            mirror_valid[i] = 1'b0;
            mirror_stamp[i] = '0;
        end
        mirror_hits     = '0;
        mirror_accesses = '0;
    endfunction

    // Look the tag up, update the mirror, and return what the block should say
    function automatic t_lookup lru_lookup(input logic [ADDR_W-1:0] addr);
        t_lookup            r;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] now;
        int                 way;
        tag = addr[ADDR_W-1:OFFSET_BITS_DEF];
        now = mirror_accesses;   // stamp is the access number before counting
        way = -1;
        r   = '{default: '0};
        for (int i = 0; i < LINES_DEF; i++) begin
            if (way < 0 && mirror_valid[i] && mirror_tag[i] == tag) way = i;
        end
        if (way >= 0) begin
            r.hit             = 1'b1;
            mirror_stamp[way] = now;
            mirror_hits       = sat_incr(mirror_hits);
        end else begin
            // lowest free line first
            for (int i = 0; i < LINES_DEF; i++) begin
                if (way < 0 && !mirror_valid[i]) way = i;
            end
            // all full: oldest stamp, strict less-than keeps lowest index on ties
            if (way < 0) begin
                way = 0;
                for (int i = 1; i < LINES_DEF; i++) begin
                    if (mirror_stamp[i] < mirror_stamp[way]) way = i;
                end
                r.ev_valid = 1'b1;
                r.ev_tag   = EV_TAG_W'(mirror_tag[way]);
            end
            mirror_tag[way]   = tag;
            mirror_valid[way] = 1'b1;
            mirror_stamp[way] = now;
        end
        mirror_accesses = sat_incr(mirror_accesses);
        r.line     = LINE_USED_W'(way);
        r.hits     = mirror_hits;
        r.accesses = mirror_accesses;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result side: checks each taken word and paces ready
    // ---------------------------------------------------------------

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup want;
        if (rst_n && res_valid && res_ready) begin
            if (pending_lookups.size() == 0) begin
                errors++;
                $display("%0t ns: result word with nothing expected, line %0h hit %0b",
                         $time, res_line, res_hit);
            end else begin
                want = pending_lookups.pop_front();
                check_field("hit",             want.hit,      res_hit);
                check_field("line_used",       want.line,     res_line);
                check_field("evicted_valid",   want.ev_valid, res_ev_valid);
                check_field("evicted_tag",     want.ev_tag,   res_ev_tag);
                check_field("hits_so_far",     want.hits,     res_hits);
                check_field("accesses_so_far", want.accesses, res_accesses);
                if (want.hit) hits_seen++;
                if (want.ev_valid) evicts_seen++;
            end
        end
        // a requested hold-off is counted down here, one cycle per edge
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any accepted word on either side resets the count
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((addr_valid && addr_ready) || (res_valid && res_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WDOG_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                         $time, WDOG_LIMIT, pending_lookups.size());
                $display("simulation failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------

    // Offer one address word, hold it until taken, then log the expectation.
    // Valid is left high so a following word goes out back to back.
    task automatic send_word(input logic [ADDR_W-1:0] addr);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            addr_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        addr_valid <= 1'b1;
        addr_word  <= addr;
        do @(posedge i_clk); while (!addr_ready);
        pending_lookups.push_back(lru_lookup(addr));
        words_sent++;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_for_results();
        addr_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    function automatic void refill_pool();
        for (int i = 0; i < 32; i++) tag_pool[i] = TAG_W'($urandom);
    endfunction

    // Mostly a small working set with random offsets, so hits and evictions
    // both happen; the rest is fully random addresses.
    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(99) < 25) return $urandom;
        if ($urandom_range(99) < 2) tag_pool[$urandom_range(pool_size - 1)] = TAG_W'($urandom);
        return {tag_pool[$urandom_range(pool_size - 1)], OFFSET_BITS_DEF'($urandom)};
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Address extremes, fill of every line, then LRU evictions with refreshes
    task automatic test_directed();
        logic [TAG_W-1:0] tag;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(32'h0000_0000);   // miss, line 0
        send_word(32'h0000_003F);   // hit, same tag, offset bits all ones
        send_word(32'hFFFF_FFFF);   // miss, all-ones tag
        send_word(32'hFFFF_FFC0);   // hit on the all-ones tag
        for (int k = 2; k < LINES_DEF; k++) begin
            if (k == 2)      tag = 26'h2AA_AAAA;
            else if (k == 3) tag = 26'h155_5555;
            else             tag = TAG_W'(k * 32'h0011_1111);
            send_word({tag, OFFSET_BITS_DEF'(k)});
        end
        send_word(32'h0000_0010);                // refresh line 0
        send_word({26'h012_3456, 6'h00});        // full: evicts the oldest line
        send_word({26'h3FF_0000, 6'h15});        // evicts the next oldest
        send_word({26'h155_5555, 6'h2A});        // hit, refresh
        send_word({26'h000_0001, 6'h3F});        // skips the refreshed line
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned words, input int unsigned pool);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        pool_size      = pool;
        refill_pool();
        repeat (words) send_word(pick_address());
        wait_for_results();
    endtask

    // Receiver holds off for a long stretch while words keep coming, so the
    // output register fills and the block stops taking input.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pool_size      = 12;
        hold_request   = HOLD_LONG;
        repeat (24) send_word(pick_address());
        wait_for_results();
    endtask

    // Sender stops mid-stream until everything is back, then carries on
    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        repeat (10) send_word(pick_address());
        wait_for_results();
        repeat (10) send_word(pick_address());
        wait_for_results();
    endtask

    initial begin
        clear_mirror();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(0, 0, 120, 20);     // no idling
        test_random_traffic(70, 0, 120, 12);    // sender mostly idle
        test_random_traffic(0, 70, 120, 24);    // receiver mostly stalling
        test_output_backpressure();
        test_random_traffic(19, 19, 120, 18);   // both idle now and then
        test_sender_pause();

        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_lookups.size() != 0) begin
            errors++;
            $display("%0t ns: %0d results never arrived", $time, pending_lookups.size());
        end
        $display("Covered %0d address words: %0d hits and %0d LRU evictions,",
                 words_sent, hits_seen, evicts_seen);
        $display("under free flow, sender gaps, receiver stalls and a long hold-off.");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
